FILE: hw/rtl/image_container_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// image container stream parser assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONTAINER_STREAM_PARSER_DEFINES_SVH
`define IMAGE_CONTAINER_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ICSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ICSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/icsp_pkg.sv
// ----------------------------------------------------------------------------
// icsp_pkg
// types and constants shared by the image container stream parser
// ----------------------------------------------------------------------------
package icsp_pkg;

  // parse phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MAGIC,
    PH_FIELDS,
    PH_CAPTION,
    PH_TAGS,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_CAPTION_BYTE = 3'd0;
  localparam logic [2:0] KIND_CAPTION_END  = 3'd1;
  localparam logic [2:0] KIND_TAG_BYTE     = 3'd2;
  localparam logic [2:0] KIND_TAG_END      = 3'd3;
  localparam logic [2:0] KIND_PIXEL        = 3'd4;
  localparam logic [2:0] KIND_ERROR        = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_BAD_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_SIZE         = 3'd2;
  localparam logic [2:0] ERR_HDR_SMALL    = 3'd3;
  localparam logic [2:0] ERR_TAG_NEWLINE  = 3'd4;
  localparam logic [2:0] ERR_TAG_UNTERM   = 3'd5;

  // file format constants
  localparam logic [7:0]  MAGIC [4]    = '{8'h43, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0]  CHAR_NUL     = 8'h00;
  localparam logic [63:0] FIXED_HEADER = 64'd36;
  localparam logic [4:0]  FIELD_LAST   = 5'd31;
  localparam logic [1:0]  MAGIC_LAST   = 2'd3;
  localparam logic [1:0]  COMP_RED     = 2'd0;
  localparam logic [1:0]  COMP_GREEN   = 2'd1;
  localparam logic [1:0]  COMP_BLUE    = 2'd2;
  localparam logic [63:0] PIXEL_BYTES  = 64'd3;
  localparam logic [63:0] TWO_PIXELS   = 64'd6;

  // one input byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } icsp_item_t;

  // input register toward the parse core
  typedef struct packed {
    logic       vld;
    icsp_item_t item;
  } icsp_stage_t;

  // parse core status
  typedef struct packed {
    logic   take;
    phase_t phase;
  } icsp_core_sts_t;

endpackage

FILE: hw/rtl/icsp_if.sv
// ----------------------------------------------------------------------------
// icsp stream interfaces
// valid/ready channels for file bytes in and parse results out
// ----------------------------------------------------------------------------
interface icsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface icsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  text_byte;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [63:0] image_width;
  logic [63:0] image_height;
  logic [2:0]  error_code;
  logic        header_complete;
  logic        file_complete;

  modport source (
    output valid, output kind, output text_byte, output red, output green,
    output blue, output image_width, output image_height, output error_code,
    output header_complete, output file_complete, input ready
  );
  modport sink (
    input valid, input kind, input text_byte, input red, input green,
    input blue, input image_width, input image_height, input error_code,
    input header_complete, input file_complete, output ready
  );
endinterface

FILE: hw/rtl/icsp_in_stage.sv
// ----------------------------------------------------------------------------
// icsp_in_stage
// input register; holds one byte while the result side is stalled
// ----------------------------------------------------------------------------
module icsp_in_stage import icsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  icsp_in_if.sink     in_ch,
  input  logic        take,
  output icsp_stage_t stg
);

  logic       vld_r;
  icsp_item_t item_r;

  // ready when empty or when the held byte moves on this cycle
  assign in_ch.ready = !vld_r || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte     <= in_ch.data_byte;
      item_r.start_of_file <= in_ch.start_of_file;
    end
  end

  assign stg.vld  = vld_r;
  assign stg.item = item_r;

endmodule

FILE: hw/rtl/icsp_core.sv
// ----------------------------------------------------------------------------
// icsp_core
// parse state, per-byte decode and the result register
// ----------------------------------------------------------------------------
module icsp_core import icsp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  icsp_stage_t    stg,
  icsp_out_if.source     out_ch,
  output icsp_core_sts_t sts
);

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        mok_r, mok_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [63:0] cont_r, cont_nxt;
  logic [63:0] wid_r, wid_nxt;
  logic [63:0] hgt_r, hgt_nxt;
  logic [63:0] w3_r, w3_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        under_r, under_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;

  // result register
  logic        out_vld_r;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  text_r, text_nxt;
  logic [7:0]  ored_r, ored_nxt;
  logic [7:0]  ogrn_r, ogrn_nxt;
  logic [7:0]  oblu_r, oblu_nxt;
  logic [63:0] owid_r, ohgt_r;
  logic [2:0]  err_r, err_nxt;
  logic        hc_r, hc_nxt;
  logic        fc_r, fc_nxt;
  logic        emit;

  logic        take;
  logic        sof;
  logic [7:0]  dbyte;

  // values seen by this byte: start of file clears the parse first
  phase_t      ph_e;
  logic [4:0]  idx_e;
  logic        mok_e;
  logic [63:0] hdr_e, cont_e, wid_e, hgt_e, w3_e, prod_e;

  // decode terms
  logic [5:0]  lane_sh;
  logic [63:0] byte_lane;
  logic [9:0]  byte_x3;
  logic [63:0] mul_full;
  logic [7:0]  top_mul;
  logic [7:0]  top_sum;
  logic        size_ok;
  logic        fld_last;
  logic        mag_last;
  logic        mag_match;
  logic        rem_zero;
  logic        under_c;
  logic [63:0] rem_c;
  logic [63:0] tag_left;
  logic        tag_zero;
  logic        cont_small;
  logic        px_last;
  logic        is_nl;
  logic        is_nul;

  assign take  = stg.vld && (!out_vld_r || out_ch.ready);
  assign sof   = stg.item.start_of_file;
  assign dbyte = stg.item.data_byte;

  assign ph_e   = sof ? PH_MAGIC : phase_r;
  assign idx_e  = sof ? 5'd0 : idx_r;
  assign mok_e  = sof ? 1'b1 : mok_r;
  assign hdr_e  = sof ? 64'd0 : hdr_r;
  assign cont_e = sof ? 64'd0 : cont_r;
  assign wid_e  = sof ? 64'd0 : wid_r;
  assign hgt_e  = sof ? 64'd0 : hgt_r;
  assign w3_e   = sof ? 64'd0 : w3_r;
  assign prod_e = sof ? 64'd0 : prod_r;

  // header field byte placement and size product terms
  assign lane_sh   = {idx_e[2:0], 3'b000};
  assign byte_lane = {56'd0, dbyte} << lane_sh;
  assign byte_x3   = {2'b00, dbyte} + {1'b0, dbyte, 1'b0};
  assign mul_full  = w3_e * {56'd0, dbyte};
  assign top_mul   = w3_e[7:0] * dbyte;
  assign top_sum   = prod_e[63:56] + top_mul;
  assign size_ok   = (cont_e[55:0] == prod_e[55:0]) && (cont_e[63:56] == top_sum);
  assign fld_last  = (idx_e == FIELD_LAST);
  assign mag_last  = (idx_e[1:0] == MAGIC_LAST);
  assign mag_match = (dbyte == MAGIC[idx_e[1:0]]);

  // caption budget counts down from header size minus the fixed part
  assign rem_zero = (rem_r == 64'd0);
  assign under_c  = under_r || rem_zero;
  assign rem_c    = rem_zero ? rem_r : rem_r - 64'd1;
  assign tag_left = rem_zero ? rem_r : rem_r - 64'd1;
  assign tag_zero = (tag_left == 64'd0);

  // pixel bookkeeping on remaining content bytes
  assign cont_small = (cont_r < PIXEL_BYTES);
  assign px_last    = (rem_r < TWO_PIXELS);

  assign is_nl  = (dbyte == CHAR_NEWLINE);
  assign is_nul = (dbyte == CHAR_NUL);

  // next phase
  always_comb begin
    phase_nxt = ph_e;
    case (ph_e)
      PH_MAGIC: begin
        if (mag_last) begin
          phase_nxt = (mok_e && mag_match) ? PH_FIELDS : PH_DONE;
        end
      end
      PH_FIELDS: begin
        if (fld_last) begin
          phase_nxt = size_ok ? PH_CAPTION : PH_DONE;
        end
      end
      PH_CAPTION: begin
        if (is_nl) begin
          if (under_c) begin
            phase_nxt = PH_DONE;
          end else if (rem_c == 64'd0) begin
            phase_nxt = cont_small ? PH_DONE : PH_PIXELS;
          end else begin
            phase_nxt = PH_TAGS;
          end
        end
      end
      PH_TAGS: begin
        if (is_nl) begin
          phase_nxt = PH_DONE;
        end else if (is_nul) begin
          if (tag_zero) begin
            phase_nxt = cont_small ? PH_DONE : PH_PIXELS;
          end
        end else if (tag_zero) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_PIXELS: begin
        if (comp_r == COMP_BLUE && px_last) begin
          phase_nxt = PH_DONE;
        end
      end
      default: phase_nxt = ph_e;
    endcase
  end

  // datapath and result decode
  always_comb begin
    idx_nxt   = idx_e;
    mok_nxt   = mok_e;
    hdr_nxt   = hdr_e;
    cont_nxt  = cont_e;
    wid_nxt   = wid_e;
    hgt_nxt   = hgt_e;
    w3_nxt    = w3_e;
    prod_nxt  = prod_e;
    rem_nxt   = rem_r;
    under_nxt = under_r;
    comp_nxt  = comp_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    emit      = 1'b0;
    kind_nxt  = KIND_ERROR;
    text_nxt  = 8'd0;
    ored_nxt  = 8'd0;
    ogrn_nxt  = 8'd0;
    oblu_nxt  = 8'd0;
    err_nxt   = ERR_NONE;
    hc_nxt    = 1'b0;
    fc_nxt    = 1'b0;
    case (ph_e)
      PH_MAGIC: begin
        mok_nxt = mok_e && mag_match;
        idx_nxt = idx_e + 5'd1;
        if (mag_last) begin
          idx_nxt = 5'd0;
          if (!mok_nxt) begin
            emit    = 1'b1;
            err_nxt = ERR_BAD_MAGIC;
          end
        end
      end
      PH_FIELDS: begin
        case (idx_e[4:3])
          2'd0: hdr_nxt = hdr_e | byte_lane;
          2'd1: cont_nxt = cont_e | byte_lane;
          2'd2: begin
            wid_nxt = wid_e | byte_lane;
            w3_nxt  = w3_e + ({54'd0, byte_x3} << lane_sh);
          end
          default: begin
            hgt_nxt  = hgt_e | byte_lane;
            prod_nxt = prod_e + (mul_full << lane_sh);
          end
        endcase
        idx_nxt = idx_e + 5'd1;
        if (fld_last) begin
          idx_nxt   = 5'd0;
          rem_nxt   = hdr_e - FIXED_HEADER;
          under_nxt = (hdr_e < FIXED_HEADER);
          if (!size_ok) begin
            emit    = 1'b1;
            err_nxt = ERR_SIZE;
          end
        end
      end
      PH_CAPTION: begin
        emit      = 1'b1;
        rem_nxt   = rem_c;
        under_nxt = under_c;
        if (!is_nl) begin
          kind_nxt = KIND_CAPTION_BYTE;
          text_nxt = dbyte;
        end else if (under_c) begin
          err_nxt = ERR_HDR_SMALL;
        end else begin
          kind_nxt = KIND_CAPTION_END;
          if (rem_c == 64'd0) begin
            hc_nxt   = 1'b1;
            fc_nxt   = cont_small;
            rem_nxt  = cont_r;
            comp_nxt = COMP_RED;
          end
        end
      end
      PH_TAGS: begin
        emit = 1'b1;
        if (is_nl) begin
          err_nxt = ERR_TAG_NEWLINE;
        end else begin
          rem_nxt = tag_left;
          if (is_nul) begin
            kind_nxt = KIND_TAG_END;
            if (tag_zero) begin
              hc_nxt   = 1'b1;
              fc_nxt   = cont_small;
              rem_nxt  = cont_r;
              comp_nxt = COMP_RED;
            end
          end else if (tag_zero) begin
            err_nxt = ERR_TAG_UNTERM;
          end else begin
            kind_nxt = KIND_TAG_BYTE;
            text_nxt = dbyte;
          end
        end
      end
      PH_PIXELS: begin
        case (comp_r)
          COMP_RED: begin
            red_nxt  = dbyte;
            comp_nxt = COMP_GREEN;
          end
          COMP_GREEN: begin
            green_nxt = dbyte;
            comp_nxt  = COMP_BLUE;
          end
          default: begin
            comp_nxt = COMP_RED;
            rem_nxt  = rem_r - PIXEL_BYTES;
            emit     = 1'b1;
            kind_nxt = KIND_PIXEL;
            ored_nxt = red_r;
            ogrn_nxt = green_r;
            oblu_nxt = dbyte;
            fc_nxt   = px_last;
          end
        endcase
      end
      default: emit = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= 5'd0;
      mok_r   <= 1'b1;
      comp_r  <= COMP_RED;
      under_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      mok_r   <= mok_nxt;
      comp_r  <= comp_nxt;
      under_r <= under_nxt;
    end
  end

  // header fields, counters and held components
  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r   <= hdr_nxt;
      cont_r  <= cont_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      w3_r    <= w3_nxt;
      prod_r  <= prod_nxt;
      rem_r   <= rem_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= emit;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind_r <= kind_nxt;
      text_r <= text_nxt;
      ored_r <= ored_nxt;
      ogrn_r <= ogrn_nxt;
      oblu_r <= oblu_nxt;
      owid_r <= wid_nxt;
      ohgt_r <= hgt_nxt;
      err_r  <= err_nxt;
      hc_r   <= hc_nxt;
      fc_r   <= fc_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.text_byte       = text_r;
  assign out_ch.red             = ored_r;
  assign out_ch.green           = ogrn_r;
  assign out_ch.blue            = oblu_r;
  assign out_ch.image_width     = owid_r;
  assign out_ch.image_height    = ohgt_r;
  assign out_ch.error_code      = err_r;
  assign out_ch.header_complete = hc_r;
  assign out_ch.file_complete   = fc_r;

  assign sts.take  = take;
  assign sts.phase = phase_r;

endmodule

FILE: hw/rtl/image_container_stream_parser.sv
// ----------------------------------------------------------------------------
// image_container_stream_parser
// streaming header check and pixel extraction for an image container file
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   data_byte, start_of_file
//   out_ch   out  valid/ready   kind, text, rgb, width, height, error, flags
//
// one byte per clock sustained while out_ch is not stalled; a result is built from
// its accepted byte via the input register, then the result register
// the size product 3*width*height is built one height byte per cycle, stalls apart,
// while the header streams in, so the last header byte needs only an 8-bit fixup
// reset is synchronous, no clearing pass; parsing waits for start_of_file
// a stalled result holds the result register, and one more byte waits in the
// input register before in_ch.ready drops
// ----------------------------------------------------------------------------
`include "image_container_stream_parser_defines.svh"

module image_container_stream_parser import icsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  icsp_in_if.sink    in_ch,
  icsp_out_if.source out_ch
);

  icsp_stage_t    stg;
  icsp_core_sts_t sts;

  // input register
  icsp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (sts.take),
    .stg   (stg)
  );

  // parse core with result register
  icsp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg    (stg),
    .out_ch (out_ch),
    .sts    (sts)
  );

  // a held byte only waits behind a stalled result
  `ICSP_ASSERT_IMP(a_stall_cause, stg.vld && !sts.take, out_ch.valid && !out_ch.ready, "byte held without result stall")

  // start of file always lands in the magic check
  `ICSP_ASSERT_NEXT(a_sof_magic, sts.take && stg.item.start_of_file, sts.phase == PH_MAGIC, "start of file did not restart parse")

  // error results carry a code
  `ICSP_ASSERT_IMP(a_err_code, out_ch.valid && out_ch.kind == KIND_ERROR, out_ch.error_code != ERR_NONE, "error result without code")

  // header end only on caption end or tag end
  `ICSP_ASSERT_IMP(a_hdr_end_kind, out_ch.valid && out_ch.header_complete, out_ch.kind == KIND_CAPTION_END || out_ch.kind == KIND_TAG_END, "header end on wrong kind")

endmodule
